[hdl/qdec_pkg.sv]
// ----------------------------------------------------------------------------
// Quadrature decoder package
// Shared codes, widths and the x4 step decode for the quadrature decoder.
// ----------------------------------------------------------------------------
package qdec_pkg;

    // Request kinds carried on the input tuser bit.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_BITS = 8;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COUNTS_PER_REV   = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TICKS_PER_SECOND = 8'd1;

    // Field widths.
    localparam int unsigned CPR_BITS   = 16;
    localparam int unsigned TPS_BITS   = 14;
    localparam int unsigned EDGE_BITS  = 32;
    localparam int unsigned SPEED_BITS = 32;
    localparam int unsigned PROD_BITS  = EDGE_BITS + TPS_BITS;   // edges * ticks
    localparam int unsigned NUM_BITS   = PROD_BITS + 6;          // times 60
    localparam int unsigned DIV_BITS   = CPR_BITS + 2;           // 4 * counts
    localparam int unsigned QUO_BITS   = SPEED_BITS;

    // Reset values of the configuration registers.
    localparam logic [CPR_BITS-1:0] CPR_RESET = 16'd96;
    localparam logic [TPS_BITS-1:0] TPS_RESET = 14'd100;

    // Step direction codes.
    typedef enum logic [1:0] {
        DIR_NONE,
        DIR_FWD,
        DIR_REV
    } t_dir;

    // Forward steps: 00->10, 10->11, 11->01, 01->00.
    function automatic logic [1:0] fwd_next(input logic [1:0] prev);
        logic [1:0] nxt;
        case (prev)
            2'b00:   nxt = 2'b10;
            2'b01:   nxt = 2'b00;
            2'b10:   nxt = 2'b11;
            2'b11:   nxt = 2'b01;
            default: nxt = 2'b00;
        endcase
        return nxt;
    endfunction

    // Reverse steps: 00->01, 01->11, 11->10, 10->00.
    function automatic logic [1:0] rev_next(input logic [1:0] prev);
        logic [1:0] nxt;
        case (prev)
            2'b00:   nxt = 2'b01;
            2'b01:   nxt = 2'b11;
            2'b10:   nxt = 2'b00;
            2'b11:   nxt = 2'b10;
            default: nxt = 2'b00;
        endcase
        return nxt;
    endfunction

    // Decode one pin transition into a direction.
    function automatic t_dir step_dir(input logic [1:0] prev, input logic [1:0] cur);
        t_dir dir;
        if (cur == fwd_next(prev)) begin
            dir = DIR_FWD;
        end else if (cur == rev_next(prev)) begin
            dir = DIR_REV;
        end else begin
            dir = DIR_NONE;
        end
        return dir;
    endfunction

endpackage

[hdl/quadrature_decoder_with_speed.sv]
// A pin sample's result is registered in the output register, or in the hold register
// while the output stalls. A window tick runs capture, one multiply, one scale by 60,
// a range check and 32 steps of a shared restoring divider (skipped on saturation).
// Throughput: one sample per cycle while the output drains and no tick is in progress.
// Reset (synchronous, active low) clears position, edge count and speed, loads the
// configuration defaults and empties the output and hold registers.
// ----------------------------------------------------------------------------
// Quadrature decoder with speed measurement
// Decodes an x4 quadrature encoder into a signed position and computes speed in
// RPM on each window tick with a shared multiply and iterative divide unit.
// ----------------------------------------------------------------------------
module quadrature_decoder_with_speed
    import qdec_pkg::*;
#(
    parameter int unsigned POSITION_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CPR_BITS-1:0]       i_cfg_data,
    // Request stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [1:0] ab_pins, [7:2] zero
    input  logic                      s_axis_tuser,   // [0] req_type
    // Result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [71:0]               m_axis_tdata,   // [31:0] position, [63:32] speed_rpm,
                                                      // [64] step_error,
                                                      // [65] position_wrapped, [71:66] zero
    output logic                      m_axis_tuser    // [0] speed_updated
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_CHECK,
        S_DIV,
        S_DONE
    } t_state;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};
    localparam logic [EDGE_BITS-1:0]     EDGE_MAX = '1;
    localparam logic [SPEED_BITS-1:0]    SPEED_MAX = '1;
    localparam int unsigned              CNT_BITS = $clog2(QUO_BITS);
    localparam logic [CNT_BITS-1:0]      CNT_LAST = CNT_BITS'(QUO_BITS - 1);

    // Registers
    t_state                     r_state,   n_state;
    logic [CPR_BITS-1:0]        r_cpr,     n_cpr;
    logic [TPS_BITS-1:0]        r_tps,     n_tps;
    logic [1:0]                 r_prev,    n_prev;
    logic [POSITION_BITS-1:0]   r_pos,     n_pos;
    logic [EDGE_BITS-1:0]       r_edges,   n_edges;
    logic [SPEED_BITS-1:0]      r_speed,   n_speed;
    logic [NUM_BITS-1:0]        r_num,     n_num;
    logic [DIV_BITS-1:0]        r_rem,     n_rem;
    logic [CNT_BITS-1:0]        r_cnt,     n_cnt;
    logic                       r_sat,     n_sat;
    logic                       r_out_vld, n_out_vld;
    logic [71:0]                r_out_data, n_out_data;
    logic                       r_out_user, n_out_user;
    logic                       r_hold_vld, n_hold_vld;
    logic [71:0]                r_hold_data, n_hold_data;
    logic                       r_hold_user, n_hold_user;

    // Combinational helpers
    logic                       w_in_acc;
    logic                       w_out_free;
    t_dir                       w_dir;
    logic [DIV_BITS-1:0]        w_divisor;
    logic [PROD_BITS-1:0]       w_prod;
    logic [NUM_BITS-1:0]        w_scaled;
    logic [DIV_BITS:0]          w_trial;
    logic [DIV_BITS:0]          w_diff;
    logic signed [63:0]         w_pos_ext;
    logic [SPEED_BITS-1:0]      w_speed_new;
    logic                       w_res_vld;
    logic [71:0]                w_res_data;
    logic                       w_res_user;
    logic                       w_wrap;
    logic                       w_err;
    logic [POSITION_BITS-1:0]   w_pos_res;
    logic [SPEED_BITS-1:0]      w_speed_res;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE) && !r_hold_vld;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_vld || m_axis_tready;

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Shared arithmetic: multiplier, scale by 60 and the divider subtractor.
    assign w_divisor = {((r_cpr == '0) ? CPR_BITS'(1) : r_cpr), 2'b00};
    assign w_prod    = PROD_BITS'(r_num[EDGE_BITS-1:0]) * PROD_BITS'(r_tps);
    assign w_scaled  = {r_num[PROD_BITS-1:0], 6'b000000}
                     - {4'b0000, r_num[PROD_BITS-1:0], 2'b00};
    assign w_trial   = {r_rem, r_num[QUO_BITS-1]};
    assign w_diff    = w_trial - {1'b0, w_divisor};
    assign w_speed_new = r_sat ? SPEED_MAX : r_num[QUO_BITS-1:0];

    assign w_dir = step_dir(r_prev, s_axis_tdata[1:0]);

    // Next-state and result logic.
    always_comb begin
        n_state     = r_state;
        n_cpr       = r_cpr;
        n_tps       = r_tps;
        n_prev      = r_prev;
        n_pos       = r_pos;
        n_edges     = r_edges;
        n_speed     = r_speed;
        n_num       = r_num;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_sat       = r_sat;
        w_res_vld   = 1'b0;
        w_res_user  = 1'b0;
        w_wrap      = 1'b0;
        w_err       = 1'b0;
        w_pos_res   = r_pos;
        w_speed_res = r_speed;

        // Configuration writes; indexes off the list are ignored.
        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_COUNTS_PER_REV) begin
                n_cpr = i_cfg_data;
            end else if (i_cfg_index == CFG_TICKS_PER_SECOND) begin
                n_tps = i_cfg_data[TPS_BITS-1:0];
            end
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == REQ_TICK) begin
                        // Capture the window count and start the speed computation.
                        n_num   = {{(NUM_BITS-EDGE_BITS){1'b0}}, r_edges};
                        n_edges = '0;
                        n_state = S_MUL;
                    end else begin
                        // Pin sample: step position and count edges.
                        case (w_dir)
                            DIR_FWD: begin
                                w_wrap = (r_pos == POS_MAX);
                                n_pos  = r_pos + POSITION_BITS'(1);
                            end
                            DIR_REV: begin
                                w_wrap = (r_pos == POS_MIN);
                                n_pos  = r_pos - POSITION_BITS'(1);
                            end
                            default: begin
                                w_err = 1'b1;
                            end
                        endcase
                        if (!w_err && (r_edges != EDGE_MAX)) begin
                            n_edges = r_edges + EDGE_BITS'(1);
                        end
                        n_prev    = s_axis_tdata[1:0];
                        w_pos_res = n_pos;
                        w_res_vld = 1'b1;
                    end
                end
            end
            S_MUL: begin
                n_num   = {{(NUM_BITS-PROD_BITS){1'b0}}, w_prod};
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_num   = w_scaled;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                // Quotient fits 32 bits only if the high part is below the divisor.
                n_cnt = '0;
                if (r_num[NUM_BITS-1:QUO_BITS] >= {2'b00, w_divisor}) begin
                    n_sat   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_sat   = 1'b0;
                    n_rem   = r_num[QUO_BITS+DIV_BITS-1:QUO_BITS];
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // One restoring step: quotient bits shift in at the bottom.
                if (!w_diff[DIV_BITS]) begin
                    n_rem = w_diff[DIV_BITS-1:0];
                end else begin
                    n_rem = w_trial[DIV_BITS-1:0];
                end
                n_num[QUO_BITS-1:0] = {r_num[QUO_BITS-2:0], !w_diff[DIV_BITS]};
                n_cnt = r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_speed     = w_speed_new;
                w_speed_res = w_speed_new;
                w_res_user  = 1'b1;
                w_res_vld   = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result packing: position is reported as its low 32 bits, sign-extended.
    assign w_pos_ext  = 64'(signed'(w_pos_res));
    assign w_res_data = {6'b000000, w_wrap, w_err, w_speed_res, w_pos_ext[31:0]};

    // Output register with a one-entry hold stage behind it.
    always_comb begin
        n_out_vld   = r_out_vld;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_hold_vld  = r_hold_vld;
        n_hold_data = r_hold_data;
        n_hold_user = r_hold_user;
        if (m_axis_tready && r_out_vld) begin
            n_out_vld = 1'b0;
        end
        if (w_out_free && r_hold_vld) begin
            n_out_vld   = 1'b1;
            n_out_data  = r_hold_data;
            n_out_user  = r_hold_user;
            n_hold_vld  = 1'b0;
        end else if (w_res_vld) begin
            if (w_out_free) begin
                n_out_vld  = 1'b1;
                n_out_data = w_res_data;
                n_out_user = w_res_user;
            end else begin
                n_hold_vld  = 1'b1;
                n_hold_data = w_res_data;
                n_hold_user = w_res_user;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cpr      <= CPR_RESET;
            r_tps      <= TPS_RESET;
            r_prev     <= '0;
            r_pos      <= '0;
            r_edges    <= '0;
            r_speed    <= '0;
            r_cnt      <= '0;
            r_sat      <= 1'b0;
            r_out_vld  <= 1'b0;
            r_hold_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cpr      <= n_cpr;
            r_tps      <= n_tps;
            r_prev     <= n_prev;
            r_pos      <= n_pos;
            r_edges    <= n_edges;
            r_speed    <= n_speed;
            r_cnt      <= n_cnt;
            r_sat      <= n_sat;
            r_out_vld  <= n_out_vld;
            r_hold_vld <= n_hold_vld;
        end
        r_num       <= n_num;
        r_rem       <= n_rem;
        r_out_data  <= n_out_data;
        r_out_user  <= n_out_user;
        r_hold_data <= n_hold_data;
        r_hold_user <= n_hold_user;
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature decoder with speed testbench
// Drives pin samples and speed window ticks into the decoder with random
// request gaps and result back-pressure. It predicts every result with a local
// decoder and compares each result stream transaction field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import qdec_pkg::*;

    // One result transaction, split into its fields.
    typedef struct packed {
        logic signed [31:0] position;
        logic [31:0]        speed_rpm;
        logic               step_error;
        logic               position_wrapped;
        logic               speed_updated;
    } t_decoder_result;

    // One row of the directed sequence. When fixed is set, want holds the
    // expected result; otherwise the local decoder supplies it.
    typedef struct packed {
        logic            kind;
        logic [1:0]      pins;
        logic            fixed;
        t_decoder_result want;
    } t_stim_row;

    localparam int DIRECTED_ROWS        = 20;
    localparam int PHASES               = 7;
    localparam int PHASE_ITEMS          = 290;
    localparam int MAX_MISMATCH_REPORTS = 10;
    localparam int DRAIN_CYCLES         = 40;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CPR_BITS-1:0]       i_cfg_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata;
    logic                      s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [71:0]               m_axis_tdata;
    logic                      m_axis_tuser;

    quadrature_decoder_with_speed DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Local copy of the decoder state and its settings.
    logic [1:0]          model_pins;
    logic [31:0]         model_position;
    logic [31:0]         model_edges;
    logic [31:0]         model_speed;
    logic [CPR_BITS-1:0] model_cpr;
    logic [TPS_BITS-1:0] model_tps;

    t_decoder_result pending_results [$];
    int              mismatch_count;

    // Idle runs: each side works in stretches that either have random waits
    // or have none.
    int send_run_left;
    bit send_calm;
    int sink_run_left;
    bit sink_calm;

    // Directed sequence, starting from the reset state with default settings.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        // Tick right after reset reports zero speed.
        '{REQ_TICK,   2'b00, 1'b1, '{32'sd0, 32'd0, 1'b0, 1'b0, 1'b1}},
        // Unchanged pins raise the step error.
        '{REQ_SAMPLE, 2'b00, 1'b1, '{32'sd0, 32'd0, 1'b1, 1'b0, 1'b0}},
        // A full forward cycle.
        '{REQ_SAMPLE, 2'b10, 1'b1, '{32'sd1, 32'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_SAMPLE, 2'b11, 1'b1, '{32'sd2, 32'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_SAMPLE, 2'b01, 1'b1, '{32'sd3, 32'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_SAMPLE, 2'b00, 1'b1, '{32'sd4, 32'd0, 1'b0, 1'b0, 1'b0}},
        // A full reverse cycle, going below zero.
        '{REQ_SAMPLE, 2'b01, 1'b1, '{32'sd3, 32'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_SAMPLE, 2'b11, 1'b1, '{32'sd2, 32'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_SAMPLE, 2'b10, 1'b1, '{32'sd1, 32'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_SAMPLE, 2'b00, 1'b1, '{32'sd0, 32'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_SAMPLE, 2'b01, 1'b1, '{-32'sd1, 32'd0, 1'b0, 1'b0, 1'b0}},
        // Both bits change, then no change: position holds.
        '{REQ_SAMPLE, 2'b10, 1'b1, '{-32'sd1, 32'd0, 1'b1, 1'b0, 1'b0}},
        '{REQ_SAMPLE, 2'b10, 1'b1, '{-32'sd1, 32'd0, 1'b1, 1'b0, 1'b0}},
        // Tick with edges counted; pins are ignored on a tick.
        '{REQ_TICK,   2'b11, 1'b0, '0},
        // Tick with an empty window gives zero speed.
        '{REQ_TICK,   2'b01, 1'b1, '{-32'sd1, 32'd0, 1'b0, 1'b0, 1'b1}},
        '{REQ_SAMPLE, 2'b11, 1'b0, '0},
        '{REQ_SAMPLE, 2'b00, 1'b0, '0},
        '{REQ_SAMPLE, 2'b01, 1'b0, '0},
        '{REQ_SAMPLE, 2'b11, 1'b0, '0},
        '{REQ_TICK,   2'b10, 1'b0, '0}
    };

    // Next pin pair one x4 step forward or backward.
    function automatic logic [1:0] advance_pins(input logic [1:0] pins, input logic forward);
        logic [1:0] nxt;
        case (pins)
            2'b00:   nxt = forward ? 2'b10 : 2'b01;
            2'b10:   nxt = forward ? 2'b11 : 2'b00;
            2'b11:   nxt = forward ? 2'b01 : 2'b10;
            default: nxt = forward ? 2'b00 : 2'b11;
        endcase
        return nxt;
    endfunction

    // Applies one accepted request to the local decoder and returns its result.
    function automatic t_decoder_result predict_item(input logic kind, input logic [1:0] pins);
        t_decoder_result res;
        t_dir            move;
        logic [63:0]     scaled_edges;
        logic [63:0]     divisor;
        logic [63:0]     quotient;
        res = '0;
        if (kind == REQ_TICK) begin
            // A zero pulse count behaves as one pulse per revolution.
            scaled_edges = model_edges * model_tps * 64'd60;
            divisor      = (model_cpr == '0) ? 64'd4 : 64'd4 * model_cpr;
            quotient     = scaled_edges / divisor;
            model_speed  = (quotient > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quotient[31:0];
            model_edges  = '0;
            res.speed_updated = 1'b1;
        end else begin
            if (pins == advance_pins(model_pins, 1'b1)) begin
                move = DIR_FWD;
            end else if (pins == advance_pins(model_pins, 1'b0)) begin
                move = DIR_REV;
            end else begin
                move = DIR_NONE;
            end
            case (move)
                DIR_FWD: begin
                    res.position_wrapped = (model_position == 32'h7FFF_FFFF);
                    model_position       = model_position + 32'd1;
                end
                DIR_REV: begin
                    res.position_wrapped = (model_position == 32'h8000_0000);
                    model_position       = model_position - 32'd1;
                end
                default: begin
                    res.step_error = 1'b1;
                end
            endcase
            // The edge count saturates rather than wrapping.
            if (move != DIR_NONE && model_edges != 32'hFFFF_FFFF) begin
                model_edges = model_edges + 32'd1;
            end
            model_pins = pins;
        end
        res.position  = model_position;
        res.speed_rpm = model_speed;
        return res;
    endfunction

    // Draws the wait before the next transaction on one side.
    function automatic int draw_wait(inout int run_left, inout bit calm);
        if (run_left == 0) begin
            run_left = $urandom_range(20, 80);
            calm     = ($urandom_range(0, 3) == 0);
        end
        run_left = run_left - 1;
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    // Sends one request and records its expected result once it is accepted.
    task automatic send_request(input logic kind, input logic [1:0] pins,
                                input logic fixed, input t_decoder_result want);
        int              gap;
        t_decoder_result predicted;
        gap = draw_wait(send_run_left, send_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, pins};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = predict_item(kind, pins);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    // Writes both registers back to back; called only while the block is idle.
    task automatic load_settings(input logic [CPR_BITS-1:0] cpr, input logic [CPR_BITS-1:0] tps);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_COUNTS_PER_REV;
        i_cfg_data  <= cpr;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_TICKS_PER_SECOND;
        i_cfg_data  <= tps;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model_cpr = cpr;
        model_tps = tps[TPS_BITS-1:0];
    endtask

    // Waits until every expected result has come back.
    task automatic drain_results();
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #2_000_000;
        $display("** quadrature_decoder_with_speed: FAILED **");
        $finish;
    end

    // Result side: random stalls, then a field-by-field check of each transaction.
    initial begin : result_sink
        int              stall;
        t_decoder_result got;
        t_decoder_result want;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait(sink_run_left, sink_calm);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.position         = m_axis_tdata[31:0];
            got.speed_rpm        = m_axis_tdata[63:32];
            got.step_error       = m_axis_tdata[64];
            got.position_wrapped = m_axis_tdata[65];
            got.speed_updated    = m_axis_tuser;
            // A result with nothing waiting compares against unknowns and fails.
            if (pending_results.size() != 0) begin
                want = pending_results.pop_front();
            end else begin
                want = 'x;
            end
            if (got !== want) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= MAX_MISMATCH_REPORTS) begin
                    $display("[%0t] result mismatch: expected pos=%0d speed=%0d err=%b wrap=%b upd=%b",
                             $realtime, want.position, want.speed_rpm, want.step_error,
                             want.position_wrapped, want.speed_updated);
                    $display("[%0t]                  actual   pos=%0d speed=%0d err=%b wrap=%b upd=%b",
                             $realtime, got.position, got.speed_rpm, got.step_error,
                             got.position_wrapped, got.speed_updated);
                end
            end
        end
    end

    // Reset, directed sequence, then random phases under several settings.
    initial begin : stimulus
        int                  phase;
        int                  n;
        int                  roll;
        logic [1:0]          stim_pins;
        logic [1:0]          pins;
        logic                heading;
        logic [CPR_BITS-1:0] cpr_set;
        logic [CPR_BITS-1:0] tps_set;

        mismatch_count = 0;
        send_run_left  = 0;
        send_calm      = 1'b0;
        sink_run_left  = 0;
        sink_calm      = 1'b0;
        model_pins     = 2'b00;
        model_position = '0;
        model_edges    = '0;
        model_speed    = '0;
        model_cpr      = 16'd96;
        model_tps      = 14'd100;
        stim_pins      = 2'b00;
        heading        = 1'b1;

        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_COUNTS_PER_REV;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_SAMPLE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows at the reset settings.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_request(directed_rows[r].kind, directed_rows[r].pins,
                         directed_rows[r].fixed, directed_rows[r].want);
            if (directed_rows[r].kind == REQ_SAMPLE) begin
                stim_pins = directed_rows[r].pins;
            end
        end
        s_axis_tvalid <= 1'b0;
        drain_results();

        for (phase = 0; phase < PHASES; phase++) begin
            // Zero values, extremes and the all-ones write come first.
            case (phase)
                0:       begin cpr_set = 16'd0;     tps_set = 16'd0;     end
                1:       begin cpr_set = 16'd1;     tps_set = 16'hFFFF;  end
                2:       begin cpr_set = 16'hFFFF;  tps_set = 16'd1;     end
                3:       begin cpr_set = 16'd96;    tps_set = 16'd10000; end
                4:       begin cpr_set = 16'd1;     tps_set = 16'd10000; end
                default: begin
                    cpr_set = CPR_BITS'($urandom_range(1, 65535));
                    tps_set = CPR_BITS'($urandom_range(1, 10000));
                end
            endcase
            load_settings(cpr_set, tps_set);

            // Mostly runs of valid steps, with occasional reversals,
            // bad samples and window ticks.
            for (n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 6) begin
                    pins = 2'($urandom_range(0, 3));
                    send_request(REQ_TICK, pins, 1'b0, '0);
                end else if (roll < 14) begin
                    pins = ($urandom_range(0, 1) == 0) ? stim_pins : ~stim_pins;
                    send_request(REQ_SAMPLE, pins, 1'b0, '0);
                    stim_pins = pins;
                end else begin
                    if ($urandom_range(0, 9) == 0) begin
                        heading = ~heading;
                    end
                    pins = advance_pins(stim_pins, heading);
                    send_request(REQ_SAMPLE, pins, 1'b0, '0);
                    stim_pins = pins;
                end
            end
            s_axis_tvalid <= 1'b0;
            drain_results();
        end

        // Give any stray result time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** quadrature_decoder_with_speed: PASSED **");
        end else begin
            $display("** quadrature_decoder_with_speed: FAILED **");
        end
        $finish;
    end

endmodule
